// ----- rtl/rgbhsv_pkg.sv -----
package rgbhsv_pkg;

  localparam int CH_W       = 8;
  localparam int QUO_W      = 16;
  localparam int HUE_W      = 11;
  localparam int SAT_W      = 16;
  localparam int HUE_CALC_W = 12;
  localparam int MAG_W      = 10;

  localparam logic [HUE_CALC_W-1:0] HUE_TURN   = HUE_CALC_W'(1536);
  localparam logic [HUE_CALC_W-1:0] HUE_GREEN  = HUE_CALC_W'(512);
  localparam logic [HUE_CALC_W-1:0] HUE_BLUE   = HUE_CALC_W'(1024);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // one request in flight through the divider row
  typedef struct packed {
    logic [CH_W-1:0]  sat_rem;
    logic [QUO_W-1:0] sat_dvd;
    logic [QUO_W-1:0] sat_quo;
    logic [CH_W-1:0]  sat_div;
    logic [CH_W-1:0]  hue_rem;
    logic [QUO_W-1:0] hue_dvd;
    logic [QUO_W-1:0] hue_quo;
    logic [CH_W-1:0]  hue_div;
    logic             neg;
    sector_t          sector;
    logic             flat;
    logic [CH_W-1:0]  bright;
  } div_stage_t;

endpackage

// ----- rtl/rgb_to_hsv_convert.sv -----
// RGB to HSV hexcone converter, one pixel per clock while not stalled. A pixel
// passes from in_valid/in_ready to out_valid through a front register finding
// max, min and the hue sector, a row of divider cells each producing one bit
// of the saturation and hue quotients, and a back register forming the hue and
// holding the result. The row advances whenever the output register is empty
// or being read, so in_ready follows out_ready and a new pixel can enter on
// every such cycle. Hue is in 1/1536 turn, saturation is 0..65535, brightness
// is the largest channel; gray and black pixels give hue and saturation 0.
module rgb_to_hsv_convert import rgbhsv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [HUE_W-1:0] out_hue,
  output logic [SAT_W-1:0] out_saturation,
  output logic [CH_W-1:0]  out_brightness
);

  logic       en;
  logic       valid_chain [QUO_W+1];
  div_stage_t stage_chain [QUO_W+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  rgbhsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .valid_r  (valid_chain[0]),
    .stage_r  (stage_chain[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (valid_chain[i]),
      .stage_in (stage_chain[i]),
      .valid_r  (valid_chain[i+1]),
      .stage_r  (stage_chain[i+1])
    );
  end

  rgbhsv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (valid_chain[QUO_W]),
    .stage_in (stage_chain[QUO_W]),
    .valid_r  (out_valid),
    .hue_r    (out_hue),
    .sat_r    (out_saturation),
    .bright_r (out_brightness)
  );

endmodule

// ----- rtl/rgbhsv_front.sv -----
module rgbhsv_front import rgbhsv_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [CH_W-1:0] red,
  input  logic [CH_W-1:0] green,
  input  logic [CH_W-1:0] blue,
  output logic            valid_r,
  output div_stage_t      stage_r
);

  logic [CH_W-1:0]        mx, mn, d, mag;
  logic [CH_W:0]          diff;
  logic [CH_W:0]          diff_abs;
  logic [CH_W+QUO_W-1:0]  sat_num;
  sector_t                sector;
  div_stage_t             stage_nxt;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    d = mx - mn;

    // ties go to red, then green
    if (red == mx) begin
      sector = SEC_RED;
      diff   = {1'b0, green} - {1'b0, blue};
    end else if (green == mx) begin
      sector = SEC_GREEN;
      diff   = {1'b0, blue} - {1'b0, red};
    end else begin
      sector = SEC_BLUE;
      diff   = {1'b0, red} - {1'b0, green};
    end
    diff_abs = diff[CH_W] ? (~diff + 1'b1) : diff;
    mag      = diff_abs[CH_W-1:0];

    // d * 65535 as (d << 16) - d
    sat_num = {d, {QUO_W{1'b0}}} - {{QUO_W{1'b0}}, d};

    stage_nxt.sat_rem = sat_num[CH_W+QUO_W-1:QUO_W];
    stage_nxt.sat_dvd = sat_num[QUO_W-1:0];
    stage_nxt.sat_quo = '0;
    stage_nxt.sat_div = mx;
    stage_nxt.hue_rem = '0;
    stage_nxt.hue_dvd = {mag, {(QUO_W-CH_W){1'b0}}};
    stage_nxt.hue_quo = '0;
    stage_nxt.hue_div = d;
    stage_nxt.neg     = diff[CH_W];
    stage_nxt.sector  = sector;
    stage_nxt.flat    = (d == '0);
    stage_nxt.bright  = mx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

// ----- rtl/rgbhsv_cell.sv -----
module rgbhsv_cell import rgbhsv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       valid_in,
  input  div_stage_t stage_in,
  output logic       valid_r,
  output div_stage_t stage_r
);

  logic [CH_W:0] sat_t, hue_t, sat_sub, hue_sub;
  logic          sat_bit, hue_bit;
  div_stage_t    stage_nxt;

  // one restoring step for both quotients
  always_comb begin
    sat_t   = {stage_in.sat_rem, stage_in.sat_dvd[QUO_W-1]};
    hue_t   = {stage_in.hue_rem, stage_in.hue_dvd[QUO_W-1]};
    sat_sub = sat_t - {1'b0, stage_in.sat_div};
    hue_sub = hue_t - {1'b0, stage_in.hue_div};
    sat_bit = (sat_t >= {1'b0, stage_in.sat_div});
    hue_bit = (hue_t >= {1'b0, stage_in.hue_div});

    stage_nxt         = stage_in;
    stage_nxt.sat_rem = sat_bit ? sat_sub[CH_W-1:0] : sat_t[CH_W-1:0];
    stage_nxt.hue_rem = hue_bit ? hue_sub[CH_W-1:0] : hue_t[CH_W-1:0];
    stage_nxt.sat_dvd = {stage_in.sat_dvd[QUO_W-2:0], 1'b0};
    stage_nxt.hue_dvd = {stage_in.hue_dvd[QUO_W-2:0], 1'b0};
    stage_nxt.sat_quo = {stage_in.sat_quo[QUO_W-2:0], sat_bit};
    stage_nxt.hue_quo = {stage_in.hue_quo[QUO_W-2:0], hue_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

// ----- rtl/rgbhsv_back.sv -----
module rgbhsv_back import rgbhsv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_in,
  input  div_stage_t       stage_in,
  output logic             valid_r,
  output logic [HUE_W-1:0] hue_r,
  output logic [SAT_W-1:0] sat_r,
  output logic [CH_W-1:0]  bright_r
);

  logic [MAG_W-1:0]      mag;
  logic [HUE_CALC_W-1:0] mag_ext, offset, base, hue_sum;
  logic [HUE_W-1:0]      hue_nxt;
  logic [SAT_W-1:0]      sat_nxt;

  always_comb begin
    // floor of a negative ratio rounds the magnitude up
    mag     = stage_in.hue_quo[MAG_W-1:0] +
              MAG_W'(stage_in.neg && (stage_in.hue_rem != '0));
    mag_ext = HUE_CALC_W'(mag);
    offset  = stage_in.neg ? (HUE_CALC_W'(0) - mag_ext) : mag_ext;
    case (stage_in.sector)
      SEC_RED:   base = stage_in.neg ? HUE_TURN : HUE_CALC_W'(0);
      SEC_GREEN: base = HUE_GREEN;
      SEC_BLUE:  base = HUE_BLUE;
      default:   base = HUE_CALC_W'(0);
    endcase
    hue_sum = base + offset;
    hue_nxt = stage_in.flat ? '0 : hue_sum[HUE_W-1:0];
    sat_nxt = stage_in.flat ? '0 : stage_in.sat_quo[SAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= stage_in.bright;
    end
  end

endmodule
